>>> rtl/core/ptt_pkg.sv
package ptt_pkg;

	// Default sizes of the table and its fields.
	localparam int TABLE_SLOTS_DEF = 64;
	localparam int ID_BITS_DEF     = 16;
	localparam int PRIO_BITS_DEF   = 32;

	// Action carried with each request.
	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_EDIT   = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_POP    = 2'd3
	} action_t;

	// Status returned with each result.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_COMMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;   // capture the request and clear the scan trackers
		logic read;    // read the slot at the scan address and step it
		logic commit;  // write back and load the result register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic addr_last; // scan address is on the last slot
		logic out_free;  // result register can take a new result
	} sts_t;

endpackage

>>> rtl/core/ptt_ctrl.sv
module ptt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  ptt_pkg::sts_t sts,
	output ptt_pkg::cmd_t cmd
);

	ptt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		s_tready   = 1'b0;
		unique case (state_q)
			ptt_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.start = 1'b1;
					state_d   = ptt_pkg::S_SCAN;
				end
			end
			ptt_pkg::S_SCAN: begin
				cmd.read = 1'b1;
				if (sts.addr_last) begin
					state_d = ptt_pkg::S_DRAIN;
				end
			end
			ptt_pkg::S_DRAIN: begin
				// The last slot read is compared in this cycle.
				state_d = ptt_pkg::S_COMMIT;
			end
			ptt_pkg::S_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ptt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ptt_pkg::S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/core/ptt_dp.sv
module ptt_dp #(
	parameter int TABLE_SLOTS = ptt_pkg::TABLE_SLOTS_DEF,
	parameter int ID_BITS     = ptt_pkg::ID_BITS_DEF,
	parameter int PRIO_BITS   = ptt_pkg::PRIO_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ptt_pkg::cmd_t          cmd,
	output ptt_pkg::sts_t          sts,
	input  ptt_pkg::action_t       in_action,
	input  logic [ID_BITS-1:0]     in_owner,
	input  logic [ID_BITS-1:0]     in_key,
	input  logic [PRIO_BITS-1:0]   in_prio,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [ID_BITS-1:0]     out_owner,
	output ptt_pkg::status_t       out_status
);

	localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int W  = 2 * ID_BITS + PRIO_BITS;

	// Slot word: task id in the low bits, then owner, then priority.
	logic [W-1:0]           mem_q [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0] valid_q;

	ptt_pkg::action_t       act_q;
	logic [ID_BITS-1:0]     owner_q;
	logic [ID_BITS-1:0]     key_q;
	logic [PRIO_BITS-1:0]   prio_q;

	logic [AW-1:0]          addr_q;
	logic [W-1:0]           rd_word_s1;
	logic                   rd_valid_s1;
	logic                   cmp_s1;
	logic [AW-1:0]          rd_idx_s1;

	logic [ID_BITS-1:0]     rd_task;
	logic [ID_BITS-1:0]     rd_owner;
	logic [PRIO_BITS-1:0]   rd_prio;

	logic                   match_hit_q;
	logic [AW-1:0]          match_slot_q;
	logic [W-1:0]           match_word_q;
	logic                   free_hit_q;
	logic [AW-1:0]          free_slot_q;
	logic                   best_hit_q;
	logic [AW-1:0]          best_slot_q;
	logic [PRIO_BITS-1:0]   best_prio_q;
	logic [ID_BITS-1:0]     best_task_q;
	logic [ID_BITS-1:0]     best_owner_q;
	logic                   better;

	logic                   we;
	logic [AW-1:0]          wa;
	logic [W-1:0]           wd;
	logic                   set_v;
	logic                   clr_v;
	logic [AW-1:0]          vslot;
	ptt_pkg::status_t       res_status;
	logic [ID_BITS-1:0]     res_owner;

	logic                   out_valid_q;
	logic [ID_BITS-1:0]     out_owner_q;
	ptt_pkg::status_t       out_status_q;

	assign sts.addr_last = (addr_q == AW'(TABLE_SLOTS - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	assign rd_task  = rd_word_s1[ID_BITS-1:0];
	assign rd_owner = rd_word_s1[2*ID_BITS-1:ID_BITS];
	assign rd_prio  = rd_word_s1[W-1:2*ID_BITS];

	// Slot store: one write port for the commit, one read port for the scan.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd_word_s1 <= mem_q[addr_q];
	end

	// Request capture, scan address and read stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			cmp_s1      <= 1'b0;
			rd_valid_s1 <= 1'b0;
			rd_idx_s1   <= '0;
		end else begin
			cmp_s1 <= cmd.read;
			if (cmd.start) begin
				addr_q <= '0;
			end else if (cmd.read) begin
				rd_valid_s1 <= valid_q[addr_q];
				rd_idx_s1   <= addr_q;
				addr_q      <= addr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			act_q   <= in_action;
			owner_q <= in_owner;
			key_q   <= in_key;
			prio_q  <= in_prio;
		end
	end

	// Ties on priority go to the smaller task id.
	assign better = !best_hit_q || (rd_prio > best_prio_q) ||
	                ((rd_prio == best_prio_q) && (rd_task < best_task_q));

	// Scan trackers: id match, lowest free slot and best candidate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_hit_q <= 1'b0;
			free_hit_q  <= 1'b0;
			best_hit_q  <= 1'b0;
		end else if (cmd.start) begin
			match_hit_q <= 1'b0;
			free_hit_q  <= 1'b0;
			best_hit_q  <= 1'b0;
		end else if (cmp_s1) begin
			if (rd_valid_s1) begin
				if (rd_task == key_q) begin
					match_hit_q <= 1'b1;
				end
				if (better) begin
					best_hit_q <= 1'b1;
				end
			end else begin
				free_hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_s1) begin
			if (rd_valid_s1) begin
				if (rd_task == key_q) begin
					match_slot_q <= rd_idx_s1;
					match_word_q <= rd_word_s1;
				end
				if (better) begin
					best_slot_q  <= rd_idx_s1;
					best_prio_q  <= rd_prio;
					best_task_q  <= rd_task;
					best_owner_q <= rd_owner;
				end
			end else if (!free_hit_q) begin
				free_slot_q <= rd_idx_s1;
			end
		end
	end

	// Outcome of the action once the scan has finished.
	always_comb begin
		we         = 1'b0;
		wa         = match_slot_q;
		wd         = {prio_q, owner_q, key_q};
		set_v      = 1'b0;
		clr_v      = 1'b0;
		vslot      = match_slot_q;
		res_status = ptt_pkg::ST_OK;
		res_owner  = '0;
		unique case (act_q)
			ptt_pkg::ACT_ADD: begin
				if (match_hit_q) begin
					we = 1'b1;
				end else if (free_hit_q) begin
					we    = 1'b1;
					wa    = free_slot_q;
					set_v = 1'b1;
					vslot = free_slot_q;
				end else begin
					res_status = ptt_pkg::ST_FULL;
				end
			end
			ptt_pkg::ACT_EDIT: begin
				wd = {prio_q, match_word_q[2*ID_BITS-1:0]};
				if (match_hit_q) begin
					we = 1'b1;
				end else begin
					res_status = ptt_pkg::ST_NOT_FOUND;
				end
			end
			ptt_pkg::ACT_REMOVE: begin
				if (match_hit_q) begin
					clr_v = 1'b1;
				end else begin
					res_status = ptt_pkg::ST_NOT_FOUND;
				end
			end
			ptt_pkg::ACT_POP: begin
				vslot = best_slot_q;
				if (best_hit_q) begin
					clr_v     = 1'b1;
					res_owner = best_owner_q;
				end else begin
					res_status = ptt_pkg::ST_EMPTY;
				end
			end
			default: begin
				res_status = ptt_pkg::ST_OK;
			end
		endcase
		we    = we && cmd.commit;
		set_v = set_v && cmd.commit;
		clr_v = clr_v && cmd.commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (set_v) begin
			valid_q[vslot] <= 1'b1;
		end else if (clr_v) begin
			valid_q[vslot] <= 1'b0;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_owner_q  <= res_owner;
			out_status_q <= res_status;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_owner  = out_owner_q;
	assign out_status = out_status_q;

endmodule

>>> rtl/core/priority_task_table.sv
// A request is taken in the idle state, the table is scanned one slot per
// cycle through the single read port of the slot store, then a drain state
// finishes the last comparison and the result is registered at the commit.
// No new request is taken until the commit of the last one, and the commit
// waits while the result side stalls.
// Reset: arst_n clears all valid bits, the controller and the valid flag of the result register at once.
module priority_task_table #(
	parameter int TABLE_SLOTS = ptt_pkg::TABLE_SLOTS_DEF,
	parameter int ID_BITS     = ptt_pkg::ID_BITS_DEF,
	parameter int PRIO_BITS   = ptt_pkg::PRIO_BITS_DEF,
	localparam int IN_W  = ((2 * ID_BITS + PRIO_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((ID_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	// Request channel.
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // owner_id, task_key, new_priority, zero padding
	input  logic [1:0]       s_tuser,  // action
	// Result channel.
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,  // popped_owner, zero padding
	output logic [1:0]       m_tuser   // status
);

	// The controller sequences each request through capture, a full scan of the
	// table, a drain state for the last comparison and a commit. The commit
	// waits until the result register is free, so a result that has not been
	// taken lets the following request be captured and scanned but holds its commit.
	ptt_pkg::cmd_t      cmd;
	ptt_pkg::sts_t      sts;
	logic [ID_BITS-1:0] out_owner;
	ptt_pkg::status_t   out_status;

	ptt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the slot store, the valid bits, the scan trackers that
	// find the matching id, the lowest free slot and the best candidate for a
	// pop, and the result register.
	ptt_dp #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.ID_BITS     (ID_BITS),
		.PRIO_BITS   (PRIO_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_action  (ptt_pkg::action_t'(s_tuser)),
		.in_owner   (s_tdata[ID_BITS-1:0]),
		.in_key     (s_tdata[2*ID_BITS-1:ID_BITS]),
		.in_prio    (s_tdata[2*ID_BITS+PRIO_BITS-1:2*ID_BITS]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_owner  (out_owner),
		.out_status (out_status)
	);

	// The popped owner sits in the low bits with zero padding above it.
	assign m_tdata = OUT_W'(out_owner);
	assign m_tuser = out_status;

endmodule

>>> rtl/core/ptt_check.sv
module ptt_check #(
	parameter int OUT_W = 16
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic [1:0]       m_tuser
);

	// A stalled result keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// The block is busy scanning right after it takes a request.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken during a scan");

	// No result can come straight out of an accepted request.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared without a scan");

	// A failed request carries a zero owner.
	a_owner_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ptt_pkg::ST_OK) |-> (m_tdata == '0))
		else $error("owner set on a failed request");

endmodule

bind priority_task_table ptt_check #(.OUT_W(OUT_W)) u_ptt_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
